FILE: rtl/tls_pkg.sv
// shared types and constants for the tote lift sequencer
package tls_pkg;

  localparam int DRIVE_BITS_DEF = 11;
  localparam int TICK_BITS_DEF  = 12;
  localparam int GATE_BITS      = 8;
  localparam int CFG_IDX_BITS   = 3;

  // reset values of the timing registers, in 20 ms ticks
  localparam int AFTER_CYCLE_RST = 25;    // half a second
  localparam int GATE_RST        = 12;    // a quarter second must be exceeded
  localparam int SAFETY_RST      = 1500;  // thirty seconds

  typedef enum logic [3:0] {
    ACT_TICK        = 4'd0,
    ACT_RAISE       = 4'd1,
    ACT_LOWER       = 4'd2,
    ACT_LIFT_STOP   = 4'd3,
    ACT_INTAKE_RUN  = 4'd4,
    ACT_INTAKE_STOP = 4'd5,
    ACT_ALL_STOP    = 4'd6,
    ACT_AUTO_START  = 4'd7,
    ACT_AUTO_STOP   = 4'd8,
    ACT_PAUSE       = 4'd9,
    ACT_RESUME      = 4'd10,
    ACT_HOLD        = 4'd11,
    ACT_RELEASE     = 4'd12,
    ACT_TELEOP      = 4'd13,
    ACT_AUTONOMOUS  = 4'd14,
    ACT_DISABLED    = 4'd15
  } action_t;

  typedef enum logic [2:0] {
    PH_TOP    = 3'd0,
    PH_GATE   = 3'd1,
    PH_FIRST  = 3'd2,
    PH_LOWER  = 3'd3,
    PH_BOTTOM = 3'd4,
    PH_HOLD   = 3'd5,
    PH_AFTER  = 3'd6,
    PH_RAISE  = 3'd7
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_RAISE_DRIVE    = 3'd0,
    CFG_LOWER_DRIVE    = 3'd1,
    CFG_STOP_DRIVE     = 3'd2,
    CFG_TOP_HOLD_DRIVE = 3'd3,
    CFG_INTAKE_DRIVE   = 3'd4,
    CFG_AFTER_TICKS    = 3'd5,
    CFG_GATE_TICKS     = 3'd6,
    CFG_SAFETY_TICKS   = 3'd7
  } cfg_idx_t;

endpackage

FILE: rtl/tote_lift_sequencer.sv
// tote lift sequencer top level: command decode, lift phase machine and result register
//
// Every input beat is either a 20 ms tick or a command, together with the four
// sensor levels, and produces exactly one result beat with the drive levels,
// the auto and hold flags and the lift phase. The whole update is one pass of
// combinational logic from the accepted beat and the current state into the
// state registers and the result register, so a beat is taken in every cycle
// and its result appears in the next cycle; the only thing holding off input
// is the result register itself when the downstream side is not taking it.
// Drives are signed Q1.10 values, only copied, never computed. Timing registers
// count ticks (after_cycle 25, gate 12, safety 1500 after reset). Configuration
// is written by the user through the plain write port while the block is idle, unenforced.
module tote_lift_sequencer #(
  parameter int DRIVE_BITS = tls_pkg::DRIVE_BITS_DEF,
  parameter int TICK_BITS  = tls_pkg::TICK_BITS_DEF,
  localparam int CFG_W     = (DRIVE_BITS > TICK_BITS) ?
                             ((DRIVE_BITS > tls_pkg::GATE_BITS) ? DRIVE_BITS : tls_pkg::GATE_BITS) :
                             ((TICK_BITS > tls_pkg::GATE_BITS) ? TICK_BITS : tls_pkg::GATE_BITS),
  localparam int OUT_USED  = 2 * DRIVE_BITS + 5,
  localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_wr_en,
  input  logic [tls_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]                cfg_wdata,
  // input beats
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,  // intake_beam_broken, top_beam_broken,
                                                     // lift_at_bottom, lift_at_top, zero pad
  input  logic [3:0]                      in_tuser,  // action
  // result beats
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [OUT_W-1:0]                out_tdata  // lift_drive, roller_drive, auto_on,
                                                     // hold_request, lift_phase, zero pad
);

  localparam int PAD_W = OUT_W - OUT_USED;

  // configuration registers
  logic signed [DRIVE_BITS-1:0] raise_drive_r, lower_drive_r, stop_drive_r;
  logic signed [DRIVE_BITS-1:0] top_hold_drive_r, intake_run_drive_r;
  logic [TICK_BITS-1:0]         after_cycle_ticks_r, safety_ticks_r;
  logic [tls_pkg::GATE_BITS-1:0] gate_ticks_r;

  // sequencer state
  tls_pkg::phase_t              phase_r, phase_nxt;
  logic                         auto_enabled_r, auto_enabled_nxt;
  logic                         prepare_remove_r, prepare_remove_nxt;
  logic                         first_tote_r, first_tote_nxt;
  logic signed [DRIVE_BITS-1:0] lift_level_r, lift_level_nxt;
  logic signed [DRIVE_BITS-1:0] roller_level_r, roller_level_nxt;
  logic signed [DRIVE_BITS-1:0] paused_level_r, paused_level_nxt;
  logic [TICK_BITS-1:0]         delay_count_r, delay_count_nxt;
  logic [TICK_BITS-1:0]         safety_count_r, safety_count_nxt;

  // result register
  logic                         out_valid_r;
  logic [OUT_W-1:0]             out_data_r, out_data_nxt;

  logic                         in_accept;
  tls_pkg::action_t             action;
  logic                         ib, tb, bot, top;

  assign action    = tls_pkg::action_t'(in_tuser);
  assign ib        = in_tdata[0];
  assign tb        = in_tdata[1];
  assign bot       = in_tdata[2];
  assign top       = in_tdata[3];

  // result register frees up in the same cycle it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raise_drive_r       <= '0;
      lower_drive_r       <= '0;
      stop_drive_r        <= '0;
      top_hold_drive_r    <= '0;
      intake_run_drive_r  <= '0;
      after_cycle_ticks_r <= TICK_BITS'(tls_pkg::AFTER_CYCLE_RST);
      gate_ticks_r        <= tls_pkg::GATE_BITS'(tls_pkg::GATE_RST);
      safety_ticks_r      <= TICK_BITS'(tls_pkg::SAFETY_RST);
    end else if (cfg_wr_en) begin
      unique case (tls_pkg::cfg_idx_t'(cfg_index))
        tls_pkg::CFG_RAISE_DRIVE:    raise_drive_r       <= cfg_wdata[DRIVE_BITS-1:0];
        tls_pkg::CFG_LOWER_DRIVE:    lower_drive_r       <= cfg_wdata[DRIVE_BITS-1:0];
        tls_pkg::CFG_STOP_DRIVE:     stop_drive_r        <= cfg_wdata[DRIVE_BITS-1:0];
        tls_pkg::CFG_TOP_HOLD_DRIVE: top_hold_drive_r    <= cfg_wdata[DRIVE_BITS-1:0];
        tls_pkg::CFG_INTAKE_DRIVE:   intake_run_drive_r  <= cfg_wdata[DRIVE_BITS-1:0];
        tls_pkg::CFG_AFTER_TICKS:    after_cycle_ticks_r <= cfg_wdata[TICK_BITS-1:0];
        tls_pkg::CFG_GATE_TICKS:     gate_ticks_r        <= cfg_wdata[tls_pkg::GATE_BITS-1:0];
        tls_pkg::CFG_SAFETY_TICKS:   safety_ticks_r      <= cfg_wdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // next state: command first, then safety timeout, then one auto step on a tick
  always_comb begin
    logic [TICK_BITS-1:0] delay_inc;
    logic                 gate_done;
    phase_nxt          = phase_r;
    auto_enabled_nxt   = auto_enabled_r;
    prepare_remove_nxt = prepare_remove_r;
    first_tote_nxt     = first_tote_r;
    lift_level_nxt     = lift_level_r;
    roller_level_nxt   = roller_level_r;
    paused_level_nxt   = paused_level_r;
    delay_count_nxt    = delay_count_r;
    safety_count_nxt   = safety_count_r;

    // command decode; manual drives only count while auto is off
    unique case (action)
      tls_pkg::ACT_TICK: ;
      tls_pkg::ACT_RAISE: begin
        if (!auto_enabled_r) begin
          lift_level_nxt   = raise_drive_r;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_LOWER: begin
        if (!auto_enabled_r) begin
          lift_level_nxt   = lower_drive_r;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_LIFT_STOP: begin
        if (!auto_enabled_r) begin
          lift_level_nxt   = stop_drive_r;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_INTAKE_RUN: begin
        if (!auto_enabled_r) begin
          roller_level_nxt = intake_run_drive_r;
          safety_count_nxt = '0;
        end
      end
      // intake stop leaves the roller level alone
      tls_pkg::ACT_INTAKE_STOP: begin
        if (!auto_enabled_r) safety_count_nxt = '0;
      end
      tls_pkg::ACT_ALL_STOP: begin
        if (!auto_enabled_r) begin
          lift_level_nxt   = stop_drive_r;
          paused_level_nxt = '0;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_AUTO_START: begin
        if (!auto_enabled_r) begin
          auto_enabled_nxt = 1'b1;
          paused_level_nxt = '0;
          phase_nxt        = tls_pkg::PH_RAISE;
          roller_level_nxt = intake_run_drive_r;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_AUTO_STOP: begin
        if (auto_enabled_r) begin
          auto_enabled_nxt = 1'b0;
          lift_level_nxt   = stop_drive_r;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_PAUSE: begin
        if (auto_enabled_r) begin
          auto_enabled_nxt = 1'b0;
          paused_level_nxt = lift_level_r;
          lift_level_nxt   = stop_drive_r;
          safety_count_nxt = '0;
        end
      end
      // resume whenever auto is off, restoring the saved lift drive
      tls_pkg::ACT_RESUME: begin
        if (!auto_enabled_r) begin
          lift_level_nxt   = paused_level_r;
          roller_level_nxt = intake_run_drive_r;
          auto_enabled_nxt = 1'b1;
          safety_count_nxt = '0;
        end
      end
      tls_pkg::ACT_HOLD: begin
        if (auto_enabled_r) prepare_remove_nxt = 1'b1;
      end
      tls_pkg::ACT_RELEASE: prepare_remove_nxt = 1'b0;
      tls_pkg::ACT_TELEOP: begin
        auto_enabled_nxt = 1'b1;
        roller_level_nxt = intake_run_drive_r;
        paused_level_nxt = '0;
        phase_nxt        = tls_pkg::PH_RAISE;
        safety_count_nxt = '0;
      end
      tls_pkg::ACT_AUTONOMOUS: begin
        roller_level_nxt = '0;
        safety_count_nxt = '0;
      end
      tls_pkg::ACT_DISABLED: safety_count_nxt = '0;
      default: ;
    endcase

    // safety counter advances on ticks and saturates
    if (action == tls_pkg::ACT_TICK && safety_count_nxt != '1) begin
      safety_count_nxt = safety_count_nxt + 1'b1;
    end
    if (safety_count_nxt > safety_ticks_r) begin
      lift_level_nxt   = stop_drive_r;
      safety_count_nxt = '0;
    end

    delay_inc = (delay_count_r == '1) ? delay_count_r : delay_count_r + 1'b1;
    gate_done = {{(CFG_W-TICK_BITS){1'b0}}, delay_inc} >
                {{(CFG_W-tls_pkg::GATE_BITS){1'b0}}, gate_ticks_r};

    // lift phase machine, one step per tick while auto is on
    if (action == tls_pkg::ACT_TICK && auto_enabled_nxt) begin
      safety_count_nxt = '0;
      unique case (phase_r)
        tls_pkg::PH_TOP: begin
          if (tb && ib) prepare_remove_nxt = 1'b1;
          if (ib || prepare_remove_nxt) begin
            if (first_tote_r) begin
              lift_level_nxt = top_hold_drive_r;
              phase_nxt      = tls_pkg::PH_FIRST;
            end else begin
              delay_count_nxt = '0;
              phase_nxt       = tls_pkg::PH_GATE;
              lift_level_nxt  = lower_drive_r;
            end
          end else begin
            lift_level_nxt = top_hold_drive_r;
          end
        end
        tls_pkg::PH_GATE: begin
          delay_count_nxt = delay_inc;
          if (gate_done) phase_nxt = tls_pkg::PH_LOWER;
        end
        tls_pkg::PH_FIRST: begin
          if (!ib) begin
            first_tote_nxt = 1'b0;
            phase_nxt      = tls_pkg::PH_TOP;
          end
        end
        tls_pkg::PH_LOWER: begin
          if (!bot) begin
            lift_level_nxt = lower_drive_r;
          end else begin
            phase_nxt      = tls_pkg::PH_BOTTOM;
            lift_level_nxt = '0;
          end
        end
        tls_pkg::PH_BOTTOM: begin
          if (prepare_remove_nxt) begin
            phase_nxt = tls_pkg::PH_HOLD;
          end else begin
            phase_nxt      = tls_pkg::PH_RAISE;
            lift_level_nxt = raise_drive_r;
          end
        end
        // wait for the stack to be pulled off the intake
        tls_pkg::PH_HOLD: begin
          if (!ib) begin
            first_tote_nxt     = 1'b1;
            prepare_remove_nxt = 1'b0;
            phase_nxt          = tls_pkg::PH_AFTER;
            delay_count_nxt    = '0;
          end else begin
            lift_level_nxt = lower_drive_r;
          end
        end
        tls_pkg::PH_AFTER: begin
          delay_count_nxt = delay_inc;
          if (delay_inc > after_cycle_ticks_r) phase_nxt = tls_pkg::PH_RAISE;
        end
        tls_pkg::PH_RAISE: begin
          if (!top) begin
            lift_level_nxt = raise_drive_r;
          end else begin
            phase_nxt      = tls_pkg::PH_TOP;
            lift_level_nxt = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result beat packing from the updated state
  always_comb begin
    out_data_nxt = {{PAD_W{1'b0}}, phase_nxt, prepare_remove_nxt, auto_enabled_nxt,
                    roller_level_nxt, lift_level_nxt};
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= tls_pkg::PH_TOP;
      auto_enabled_r   <= 1'b0;
      prepare_remove_r <= 1'b0;
      first_tote_r     <= 1'b1;
      lift_level_r     <= '0;
      roller_level_r   <= '0;
      paused_level_r   <= '0;
      delay_count_r    <= '0;
      safety_count_r   <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r          <= phase_nxt;
        auto_enabled_r   <= auto_enabled_nxt;
        prepare_remove_r <= prepare_remove_nxt;
        first_tote_r     <= first_tote_nxt;
        lift_level_r     <= lift_level_nxt;
        roller_level_r   <= roller_level_nxt;
        paused_level_r   <= paused_level_nxt;
        delay_count_r    <= delay_count_nxt;
        safety_count_r   <= safety_count_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_tready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // result data only loads with an accepted beat
  always_ff @(posedge clk) begin
    if (in_accept) out_data_r <= out_data_nxt;
  end

  // every accepted beat leaves a result pending
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted beat left no result");

  // with auto off, only auto start or teleop can move the phase
  a_phase_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !auto_enabled_r && action != tls_pkg::ACT_AUTO_START &&
     action != tls_pkg::ACT_TELEOP) |=> phase_r == $past(phase_r))
    else $error("phase moved while auto was off");

  // an auto tick always clears the safety count
  a_auto_tick_clears_safety: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && action == tls_pkg::ACT_TICK && auto_enabled_r) |=> safety_count_r == '0)
    else $error("safety count not cleared by auto tick");

  // release always drops the hold request
  a_release_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && action == tls_pkg::ACT_RELEASE) |=> !prepare_remove_r)
    else $error("hold request survived release");

endmodule

FILE: tb/tb.sv
// testbench for the tote lift sequencer: command stimulus, result prediction and checking
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // result beat as it sits on out_tdata, lowest field at the bottom
  typedef struct packed {
    logic [4:0]       pad;
    tls_pkg::phase_t  lift_phase;
    logic             hold_req;
    logic             auto_on;
    logic [10:0]      roller;
    logic [10:0]      lift;
  } lift_result_t;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 10;

  // tracks the lift state machine, drive levels and timers beat by beat
  // and holds the results still owed by the block
  class lift_scoreboard;
    logic [10:0]      raise_lvl, lower_lvl, stop_lvl, top_hold_lvl, run_lvl;
    logic [11:0]      after_lim, safety_lim;
    logic [7:0]       gate_lim;
    tls_pkg::phase_t  ph;
    logic             auto_en, prep_remove, first_tote;
    logic [10:0]      lift_lvl, roller_lvl, paused_lvl;
    logic [11:0]      delay_cnt, safety_cnt;
    lift_result_t     owed_q[$];
    int               n_checked, n_errors;

    function new();
      raise_lvl = '0; lower_lvl = '0; stop_lvl = '0; top_hold_lvl = '0; run_lvl = '0;
      after_lim = 12'(tls_pkg::AFTER_CYCLE_RST);
      gate_lim = 8'(tls_pkg::GATE_RST);
      safety_lim = 12'(tls_pkg::SAFETY_RST);
      ph = tls_pkg::PH_TOP;
      auto_en = 1'b0; prep_remove = 1'b0; first_tote = 1'b1;
      lift_lvl = '0; roller_lvl = '0; paused_lvl = '0;
      delay_cnt = '0; safety_cnt = '0;
      n_checked = 0; n_errors = 0;
    endfunction

    function void write_reg(tls_pkg::cfg_idx_t idx, logic [11:0] val);
      case (idx)
        tls_pkg::CFG_RAISE_DRIVE:    raise_lvl = val[10:0];
        tls_pkg::CFG_LOWER_DRIVE:    lower_lvl = val[10:0];
        tls_pkg::CFG_STOP_DRIVE:     stop_lvl = val[10:0];
        tls_pkg::CFG_TOP_HOLD_DRIVE: top_hold_lvl = val[10:0];
        tls_pkg::CFG_INTAKE_DRIVE:   run_lvl = val[10:0];
        tls_pkg::CFG_AFTER_TICKS:    after_lim = val;
        tls_pkg::CFG_GATE_TICKS:     gate_lim = val[7:0];
        tls_pkg::CFG_SAFETY_TICKS:   safety_lim = val;
        default: ;
      endcase
    endfunction

    function logic [11:0] bump(logic [11:0] v);
      return (v == 12'hFFF) ? v : v + 12'd1;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // apply one accepted beat and queue the result it owes
    function void note_beat(tls_pkg::action_t act, logic [3:0] sens);
      logic beam_in, beam_top, at_bot, at_top;
      lift_result_t r;
      beam_in = sens[0]; beam_top = sens[1]; at_bot = sens[2]; at_top = sens[3];
      case (act)
        tls_pkg::ACT_RAISE: begin
          if (!auto_en) begin lift_lvl = raise_lvl; safety_cnt = '0; end
        end
        tls_pkg::ACT_LOWER: begin
          if (!auto_en) begin lift_lvl = lower_lvl; safety_cnt = '0; end
        end
        tls_pkg::ACT_LIFT_STOP: begin
          if (!auto_en) begin lift_lvl = stop_lvl; safety_cnt = '0; end
        end
        tls_pkg::ACT_INTAKE_RUN: begin
          if (!auto_en) begin roller_lvl = run_lvl; safety_cnt = '0; end
        end
        tls_pkg::ACT_INTAKE_STOP: if (!auto_en) safety_cnt = '0;
        tls_pkg::ACT_ALL_STOP: begin
          if (!auto_en) begin
            lift_lvl = stop_lvl; paused_lvl = '0; safety_cnt = '0;
          end
        end
        tls_pkg::ACT_AUTO_START: begin
          if (!auto_en) begin
            auto_en = 1'b1; paused_lvl = '0; ph = tls_pkg::PH_RAISE;
            roller_lvl = run_lvl; safety_cnt = '0;
          end
        end
        tls_pkg::ACT_AUTO_STOP: begin
          if (auto_en) begin auto_en = 1'b0; lift_lvl = stop_lvl; safety_cnt = '0; end
        end
        tls_pkg::ACT_PAUSE: begin
          if (auto_en) begin
            auto_en = 1'b0; paused_lvl = lift_lvl; lift_lvl = stop_lvl; safety_cnt = '0;
          end
        end
        tls_pkg::ACT_RESUME: begin
          if (!auto_en) begin
            lift_lvl = paused_lvl; roller_lvl = run_lvl; auto_en = 1'b1; safety_cnt = '0;
          end
        end
        tls_pkg::ACT_HOLD:    if (auto_en) prep_remove = 1'b1;
        tls_pkg::ACT_RELEASE: prep_remove = 1'b0;
        tls_pkg::ACT_TELEOP: begin
          auto_en = 1'b1; roller_lvl = run_lvl; paused_lvl = '0;
          ph = tls_pkg::PH_RAISE; safety_cnt = '0;
        end
        tls_pkg::ACT_AUTONOMOUS: begin roller_lvl = '0; safety_cnt = '0; end
        tls_pkg::ACT_DISABLED:   safety_cnt = '0;
        default: ;
      endcase

      if (act == tls_pkg::ACT_TICK) safety_cnt = bump(safety_cnt);
      if (safety_cnt > safety_lim) begin
        lift_lvl = stop_lvl;
        safety_cnt = '0;
      end

      // one step of the auto cycle per tick
      if (act == tls_pkg::ACT_TICK && auto_en) begin
        safety_cnt = '0;
        case (ph)
          tls_pkg::PH_TOP: begin
            if (beam_top && beam_in) prep_remove = 1'b1;
            if (beam_in || prep_remove) begin
              if (first_tote) begin
                lift_lvl = top_hold_lvl;
                ph = tls_pkg::PH_FIRST;
              end else begin
                delay_cnt = '0;
                ph = tls_pkg::PH_GATE;
                lift_lvl = lower_lvl;
              end
            end else begin
              lift_lvl = top_hold_lvl;
            end
          end
          tls_pkg::PH_GATE: begin
            delay_cnt = bump(delay_cnt);
            if (delay_cnt > gate_lim) ph = tls_pkg::PH_LOWER;
          end
          tls_pkg::PH_FIRST: begin
            if (!beam_in) begin first_tote = 1'b0; ph = tls_pkg::PH_TOP; end
          end
          tls_pkg::PH_LOWER: begin
            if (!at_bot) lift_lvl = lower_lvl;
            else begin ph = tls_pkg::PH_BOTTOM; lift_lvl = '0; end
          end
          tls_pkg::PH_BOTTOM: begin
            if (prep_remove) ph = tls_pkg::PH_HOLD;
            else begin ph = tls_pkg::PH_RAISE; lift_lvl = raise_lvl; end
          end
          tls_pkg::PH_HOLD: begin
            if (!beam_in) begin
              first_tote = 1'b1; prep_remove = 1'b0;
              ph = tls_pkg::PH_AFTER; delay_cnt = '0;
            end else begin
              lift_lvl = lower_lvl;
            end
          end
          tls_pkg::PH_AFTER: begin
            delay_cnt = bump(delay_cnt);
            if (delay_cnt > after_lim) ph = tls_pkg::PH_RAISE;
          end
          default: begin
            if (!at_top) lift_lvl = raise_lvl;
            else begin ph = tls_pkg::PH_TOP; lift_lvl = '0; end
          end
        endcase
      end

      r.pad = '0;
      r.lift_phase = ph;
      r.hold_req = prep_remove;
      r.auto_on = auto_en;
      r.roller = roller_lvl;
      r.lift = lift_lvl;
      owed_q.push_back(r);
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      if (n_errors < 10)
        $display("result %0d %s: expected %0h got %0h", n_checked, what, want, got);
      n_errors++;
    endfunction

    function void check_beat(logic [31:0] data);
      lift_result_t got, want;
      got = lift_result_t'(data);
      if (owed_q.size() == 0) begin
        flag("arrived with nothing owed", '0, data);
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      if (got.lift !== want.lift) flag("lift_drive", want.lift, got.lift);
      if (got.roller !== want.roller) flag("roller_drive", want.roller, got.roller);
      if (got.auto_on !== want.auto_on) flag("auto_on", want.auto_on, got.auto_on);
      if (got.hold_req !== want.hold_req) flag("hold_request", want.hold_req, got.hold_req);
      if (got.lift_phase !== want.lift_phase)
        flag("lift_phase", want.lift_phase, got.lift_phase);
      if (got.pad !== want.pad) flag("pad bits", want.pad, got.pad);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  tls_pkg::cfg_idx_t  cfg_index = tls_pkg::CFG_RAISE_DRIVE;
  logic [11:0]        cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;   // intake_beam_broken, top_beam_broken, lift_at_bottom,
                                       // lift_at_top, zero pad
  logic [3:0]         in_tuser = '0;   // action
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;       // lift_drive, roller_drive, auto_on, hold_request,
                                       // lift_phase, zero pad

  lift_scoreboard sb;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
  int hold_off_len = 0;    // requested long receiver hold-off, in cycles
  int n_sent = 0;
  int quiet_cycles = 0;

  tote_lift_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when asked for one
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every accepted result beat goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata);
  end

  // watchdog: ends the run when no beat and no write moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results owed",
               WATCHDOG_LIMIT, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register write; only called while nothing is in flight
  task automatic set_reg(tls_pkg::cfg_idx_t idx, logic [11:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // offer one beat, with random idle cycles ahead of it, and wait for the handshake
  task automatic send_beat(tls_pkg::action_t act, logic [3:0] sens);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0000, sens};
    do @(posedge clk); while (!in_tready);
    sb.note_beat(act, sens);
    n_sent++;
  endtask

  // sender pauses until every owed result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // sensors that mostly push the auto cycle on to its next phase
  function automatic logic [3:0] steer(tls_pkg::phase_t p);
    logic [3:0] s;
    logic push;
    s = 4'($urandom_range(15));
    push = ($urandom_range(3) != 0);
    case (p)
      tls_pkg::PH_RAISE:                   s[3] = push;   // top limit ends the raise
      tls_pkg::PH_TOP:                     s[0] = push;   // a tote at the intake starts a cycle
      tls_pkg::PH_FIRST, tls_pkg::PH_HOLD: s[0] = !push;  // intake beam clears
      tls_pkg::PH_LOWER:                   s[2] = push;   // bottom limit ends the lowering
      default: ;
    endcase
    return s;
  endfunction

  // mostly ticks with steered sensors, the rest commands and sensor noise
  task automatic send_random();
    tls_pkg::action_t act;
    logic [3:0] sens;
    if ($urandom_range(99) < 60) act = tls_pkg::ACT_TICK;
    else act = tls_pkg::action_t'($urandom_range(1, 15));
    if ($urandom_range(99) < 75) sens = steer(sb.ph);
    else sens = 4'($urandom_range(15));
    send_beat(act, sens);
  endtask

  // drive level per setting: most negative, most positive, or anything;
  // bit 11 is random so the width mask is exercised
  function automatic logic [11:0] drive_val(int k);
    logic top_bit;
    top_bit = 1'($urandom_range(1));
    if (k == 0) return {top_bit, 11'h400};
    if (k == 1) return {top_bit, 11'h3FF};
    return 12'($urandom);
  endfunction

  // all eight registers for one setting: k 0 minimum, k 1 maximum but a random safety limit, else random
  task automatic config_setting(int k);
    set_reg(tls_pkg::CFG_RAISE_DRIVE, drive_val(k));
    set_reg(tls_pkg::CFG_LOWER_DRIVE, drive_val(k));
    set_reg(tls_pkg::CFG_STOP_DRIVE, drive_val(k));
    set_reg(tls_pkg::CFG_TOP_HOLD_DRIVE, drive_val(k));
    set_reg(tls_pkg::CFG_INTAKE_DRIVE, drive_val(k));
    set_reg(tls_pkg::CFG_AFTER_TICKS, (k == 0) ? 12'd0 : (k == 1) ? 12'hFFF :
                                      12'($urandom_range(0, 6)));
    set_reg(tls_pkg::CFG_GATE_TICKS, (k == 0) ? {4'($urandom), 8'h00} :
                                     (k == 1) ? 12'h0FF : 12'($urandom_range(0, 4)));
    set_reg(tls_pkg::CFG_SAFETY_TICKS, (k == 0) ? 12'd0 :
                                       (k == 1) ? 12'($urandom_range(20, 60)) :
                                       12'($urandom_range(0, 40)));
  endtask

  initial begin
    int k;
    int idle_plan [4];
    int stall_plan [4];
    idle_plan = '{0, 75, 0, 30};
    stall_plan = '{0, 0, 75, 30};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: distinct drive levels, short timers, masked writes
    set_reg(tls_pkg::CFG_RAISE_DRIVE, 12'h3FF);
    set_reg(tls_pkg::CFG_LOWER_DRIVE, 12'hC00);
    set_reg(tls_pkg::CFG_STOP_DRIVE, 12'h155);
    set_reg(tls_pkg::CFG_TOP_HOLD_DRIVE, 12'h7FF);
    set_reg(tls_pkg::CFG_INTAKE_DRIVE, 12'h2AA);
    set_reg(tls_pkg::CFG_AFTER_TICKS, 12'd2);
    set_reg(tls_pkg::CFG_GATE_TICKS, 12'hF01);
    set_reg(tls_pkg::CFG_SAFETY_TICKS, 12'd3);

    // manual commands with auto off
    send_beat(tls_pkg::ACT_RAISE, 4'b1111);
    send_beat(tls_pkg::ACT_LOWER, 4'b0000);
    send_beat(tls_pkg::ACT_LIFT_STOP, 4'b0101);
    send_beat(tls_pkg::ACT_INTAKE_RUN, 4'b1010);
    send_beat(tls_pkg::ACT_INTAKE_STOP, 4'b0000);   // roller keeps its level
    send_beat(tls_pkg::ACT_ALL_STOP, 4'b1111);
    // commands that only matter with auto on are ignored
    send_beat(tls_pkg::ACT_AUTO_STOP, 4'b0000);
    send_beat(tls_pkg::ACT_PAUSE, 4'b1111);
    send_beat(tls_pkg::ACT_HOLD, 4'b0101);
    // resume with auto off, then pause again
    send_beat(tls_pkg::ACT_RESUME, 4'b1010);
    send_beat(tls_pkg::ACT_PAUSE, 4'b0000);
    // manual ticks run into the safety timeout on the fourth
    repeat (4) send_beat(tls_pkg::ACT_TICK, 4'b0000);
    // auto start, repeated start and manual raise ignored
    send_beat(tls_pkg::ACT_AUTO_START, 4'b0000);
    send_beat(tls_pkg::ACT_AUTO_START, 4'b1111);
    send_beat(tls_pkg::ACT_RAISE, 4'b0000);
    send_beat(tls_pkg::ACT_TICK, 4'b0000);          // still raising
    send_beat(tls_pkg::ACT_TICK, 4'b1000);          // top limit reached
    send_beat(tls_pkg::ACT_HOLD, 4'b0000);
    send_beat(tls_pkg::ACT_TICK, 4'b0001);          // first tote at the intake
    send_beat(tls_pkg::ACT_RELEASE, 4'b1111);
    // robot modes
    send_beat(tls_pkg::ACT_TELEOP, 4'b0000);
    send_beat(tls_pkg::ACT_AUTONOMOUS, 4'b1111);
    send_beat(tls_pkg::ACT_DISABLED, 4'b0000);
    drain();

    // random part under four idle/stall mixes and register settings
    for (k = 0; k < 4; k++) begin
      send_idle_pct = idle_plan[k];
      recv_stall_pct = stall_plan[k];
      config_setting(k);
      if (k == 0) begin
        // long receiver hold-off while beats keep coming, so the input backs up
        hold_off_len = 120;
        repeat (30) send_random();
      end
      repeat (110) send_random();
      drain();
    end

    // largest safety and after-cycle limits, gate at zero: a long safety window with
    // auto off, then a slow after-cycle delay
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_reg(tls_pkg::CFG_SAFETY_TICKS, 12'hFFF);
    set_reg(tls_pkg::CFG_AFTER_TICKS, 12'hFFF);
    set_reg(tls_pkg::CFG_GATE_TICKS, 12'h000);
    send_beat(tls_pkg::ACT_AUTO_STOP, 4'b0000);
    repeat (20) send_beat(tls_pkg::ACT_TICK, 4'($urandom_range(15)));
    send_beat(tls_pkg::ACT_TELEOP, 4'b0000);
    for (k = 0; k < 40 && sb.ph != tls_pkg::PH_AFTER; k++)
      send_beat(tls_pkg::ACT_TICK, steer(sb.ph));
    repeat (20) send_beat(tls_pkg::ACT_TICK, 4'($urandom_range(15)));
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input beats: directed commands, four idle/stall mixes,", n_sent);
    $display("a long output hold-off and the largest timer limits; %0d results checked, %0d owed",
             sb.n_checked, sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.n_errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tls_pkg.sv
rtl/tote_lift_sequencer.sv
tb/tb.sv
